>>> hw/rtl/vtc_pkg.sv
// ----------------------------------------------------------------------------
// vtc_pkg: shared types and constants for the valid-region convolution
// Kernel geometry, field widths, register indexes and cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtc_pkg;

    // Geometry
    localparam int KERNEL_SIZE = 5;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINES       = KERNEL_SIZE - 1;

    // Field widths
    localparam int VALUE_W   = 16;
    localparam int TAP_W     = 5;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int RESULT_W  = 22;
    localparam int POS_W     = 10;
    localparam int FRAC_W    = 14;

    // Counter and compare widths
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CNT_MAX = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_BASE = (CNT_MAX > CFG_W) ? CNT_MAX : CFG_W;
    localparam int CMP_W   = ((CMP_BASE > POS_W) ? CMP_BASE : POS_W) + 1;
    localparam int SLOT_W  = (LINES > 1) ? $clog2(LINES) : 1;

    // Accumulator widths
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int ROW_SUM_W = PROD_W + $clog2(KERNEL_SIZE);
    localparam int SUM_RAW_W = PROD_W + $clog2(TAPS);
    localparam int SUM_W     = (SUM_RAW_W > FRAC_W + RESULT_W) ? SUM_RAW_W
                                                               : FRAC_W + RESULT_W;

    // Opcodes
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_COEF_LOAD = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(1024);

    typedef logic signed [VALUE_W-1:0] sample_t;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } meta_t;

    typedef struct packed {
        logic shift;
        logic coef_we;
        logic prod;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/vtc_if.sv
// ----------------------------------------------------------------------------
// vtc_if: request channels of the convolution block
// Pixel/coefficient input, result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtc_in_if;
    import vtc_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic signed [15:0]  sample_value;
    logic [TAP_W-1:0]    coef_index;

    modport source (output valid, output opcode, output sample_value,
                    output coef_index, input ready);
    modport sink   (input valid, input opcode, input sample_value,
                    input coef_index, output ready);
endinterface

interface vtc_out_if;
    import vtc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [RESULT_W-1:0]  filtered_value;
    logic [POS_W-1:0]            out_row;
    logic [POS_W-1:0]            out_col;
    logic                        frame_last;

    modport source (output valid, output filtered_value, output out_row,
                    output out_col, output frame_last, input ready);
    modport sink   (input valid, input filtered_value, input out_row,
                    input out_col, input frame_last, output ready);
endinterface

interface vtc_cfg_if;
    import vtc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/vtc_ram.sv
// ----------------------------------------------------------------------------
// vtc_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/vtc_cell.sv
// ----------------------------------------------------------------------------
// vtc_cell: one kernel tap of the window
// Holds a window pixel and its coefficient, hands the pixel to the left
// neighbor on a shift and registers the tap product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtc_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vtc_pkg::cell_ctrl_t                ctrl,
    input  vtc_pkg::sample_t                   pixel_in,
    input  vtc_pkg::sample_t                   coef_in,
    output vtc_pkg::sample_t                   pixel_out,
    output logic signed [vtc_pkg::PROD_W-1:0]  prod_out
);
    import vtc_pkg::*;

    sample_t                   pixel_reg;
    sample_t                   coef_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '0;
            coef_reg  <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                pixel_reg <= pixel_in;
            end
            if (ctrl.coef_we)
            begin
                coef_reg <= coef_in;
            end
        end
    end

    // Register the tap product
    always_ff @(posedge clk)
    begin
        if (ctrl.prod)
        begin
            prod_reg <= pixel_reg * coef_reg;
        end
    end

    assign pixel_out = pixel_reg;
    assign prod_out  = prod_reg;

endmodule

>>> hw/rtl/valid_2d_convolution.sv
// ----------------------------------------------------------------------------
// valid_2d_convolution: streaming valid-region 2D correlation, 5x5 kernel
// Throughput: one request (pixel or coefficient load) per clock while the
//   output is not stalled. A result reaches the output register after its
//   pixel passes the line read, window shift, tap multiply, row sum and
//   total/shift stages. Reset clears coefficients, window, position counters
//   and sets both dimensions to 1024; the line store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module valid_2d_convolution (
    input  logic        clk,
    input  logic        rst_n,
    vtc_in_if.sink      sample,
    vtc_out_if.source   result,
    vtc_cfg_if.sink     cfg
);
    import vtc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers (raw value kept, clamped on use)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= DIM_RESET;
            height_cfg_reg <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    logic [CMP_W-1:0] width_raw;
    logic [CMP_W-1:0] height_raw;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;

    // Saturate the dimensions into [kernel size, maximum]
    always_comb
    begin
        width_raw  = CMP_W'(width_cfg_reg);
        height_raw = CMP_W'(height_cfg_reg);
        if (width_raw < CMP_W'(KERNEL_SIZE))
            width_eff = CMP_W'(KERNEL_SIZE);
        else if (width_raw > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = width_raw;
        if (height_raw < CMP_W'(KERNEL_SIZE))
            height_eff = CMP_W'(KERNEL_SIZE);
        else if (height_raw > CMP_W'(MAX_HEIGHT))
            height_eff = CMP_W'(MAX_HEIGHT);
        else
            height_eff = height_raw;
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage advances when it is empty or its
    // successor takes its contents, so bubbles collapse.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic w_valid_reg;
    logic p_valid_reg;
    logic r_valid_reg;
    logic t_valid_reg;
    logic en_t;
    logic en_r;
    logic en_p;
    logic en_w;
    logic en_s1;

    assign en_t  = !t_valid_reg || result.ready;
    assign en_r  = !r_valid_reg || en_t;
    assign en_p  = !p_valid_reg || en_r;
    assign en_w  = !w_valid_reg || en_p;
    assign en_s1 = !s1_valid_reg || en_w;

    assign sample.ready = en_s1;

    logic accept;
    logic pix_acc;

    assign accept  = sample.valid && sample.ready;
    assign pix_acc = accept && (sample.opcode == OP_PIXEL);

    // ------------------------------------------------------------------
    // Raster position of the next pixel; slot_reg tracks row modulo the
    // number of stored lines and names the line the pixel overwrites.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CMP_W-1:0]  col_ext;
    logic [CMP_W-1:0]  row_ext;
    logic [CMP_W-1:0]  row_pos;
    logic [CMP_W-1:0]  col_pos;
    logic              row_end;
    logic              frame_end;
    logic              emit;

    assign col_ext   = CMP_W'(col_reg);
    assign row_ext   = CMP_W'(row_reg);
    assign row_end   = (col_ext + CMP_W'(1)) >= width_eff;
    assign frame_end = row_end && ((row_ext + CMP_W'(1)) >= height_eff);
    assign emit      = (col_ext >= CMP_W'(KERNEL_SIZE - 1)) &&
                       (row_ext >= CMP_W'(KERNEL_SIZE - 1));
    assign row_pos   = row_ext - CMP_W'(KERNEL_SIZE - 1);
    assign col_pos   = col_ext - CMP_W'(KERNEL_SIZE - 1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (pix_acc)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + ROW_W'(1);
                    slot_next = (slot_reg == SLOT_W'(LINES - 1)) ? '0
                                                                 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one RAM per stored row, all read at the pixel's column.
    // The RAM whose slot matches the current row is read first, then
    // overwritten with the new pixel in the same cycle.
    // ------------------------------------------------------------------
    sample_t line_q [LINES];

    for (genvar j = 0; j < LINES; j++)
    begin : g_line
        vtc_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .clk     (clk),
            .wr_en   (pix_acc && (slot_reg == SLOT_W'(j))),
            .wr_addr (col_reg),
            .wr_data (sample.sample_value),
            .rd_en   (pix_acc),
            .rd_addr (col_reg),
            .rd_data (line_q[j])
        );
    end

    // ------------------------------------------------------------------
    // Stage S1: request waits here while the line RAMs deliver
    // ------------------------------------------------------------------
    logic              s1_load_reg;
    sample_t           s1_sample_reg;
    logic [TAP_W-1:0]  s1_tap_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_emit_reg;
    meta_t             s1_meta_reg;
    logic              s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en_s1)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg            <= (sample.opcode == OP_COEF_LOAD);
            s1_sample_reg          <= sample.sample_value;
            s1_tap_reg             <= sample.coef_index;
            s1_slot_reg            <= slot_reg;
            s1_emit_reg            <= emit;
            s1_meta_reg.out_row    <= row_pos[POS_W-1:0];
            s1_meta_reg.out_col    <= col_pos[POS_W-1:0];
            s1_meta_reg.frame_last <= frame_end;
        end
    end

    assign s1_adv = s1_valid_reg && en_w;

    // New right-hand window column: stored rows oldest first, then pixel
    logic [SLOT_W:0] rot [LINES];
    sample_t         col_in [KERNEL_SIZE];

    always_comb
    begin
        for (int r = 0; r < LINES; r++)
        begin
            rot[r] = (SLOT_W + 1)'(s1_slot_reg) + (SLOT_W + 1)'(r);
            if (rot[r] >= (SLOT_W + 1)'(LINES))
                rot[r] = rot[r] - (SLOT_W + 1)'(LINES);
            col_in[r] = line_q[rot[r][SLOT_W-1:0]];
        end
        col_in[KERNEL_SIZE-1] = s1_sample_reg;
    end

    // ------------------------------------------------------------------
    // Stage W: the cell array holds the window. A pixel shifts it left by
    // one column; a load writes one coefficient. Only pixels that complete
    // a full window stay valid past this stage.
    // ------------------------------------------------------------------
    meta_t w_meta_reg;
    logic  p_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else if (en_w)
        begin
            w_valid_reg <= s1_valid_reg && !s1_load_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            w_meta_reg <= s1_meta_reg;
        end
    end

    assign p_load = w_valid_reg && en_p;

    sample_t                  pix  [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE];

    for (genvar r = 0; r < KERNEL_SIZE; r++)
    begin : g_row
        for (genvar c = 0; c < KERNEL_SIZE; c++)
        begin : g_col
            cell_ctrl_t ctrl;
            sample_t    feed;

            assign ctrl.shift   = s1_adv && !s1_load_reg;
            assign ctrl.coef_we = s1_adv && s1_load_reg &&
                                  (int'(s1_tap_reg) == r * KERNEL_SIZE + c);
            assign ctrl.prod    = p_load;

            if (c == KERNEL_SIZE - 1)
            begin : g_edge
                assign feed = col_in[r];
            end
            else
            begin : g_inner
                assign feed = pix[r][c+1];
            end

            vtc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pixel_in  (feed),
                .coef_in   (s1_sample_reg),
                .pixel_out (pix[r][c]),
                .prod_out  (prod[r][c])
            );
        end
    end

    // ------------------------------------------------------------------
    // Stage P: tap products sit in the cells
    // ------------------------------------------------------------------
    meta_t p_meta_reg;
    logic  r_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en_p)
        begin
            p_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_meta_reg <= w_meta_reg;
        end
    end

    assign r_load = p_valid_reg && en_r;

    // ------------------------------------------------------------------
    // Stage R: one sum per window row
    // ------------------------------------------------------------------
    logic signed [ROW_SUM_W-1:0] row_sum_next [KERNEL_SIZE];
    logic signed [ROW_SUM_W-1:0] row_sum_reg  [KERNEL_SIZE];
    meta_t                       r_meta_reg;
    logic                        t_load;

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            row_sum_next[r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                row_sum_next[r] = row_sum_next[r] + ROW_SUM_W'(prod[r][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (en_r)
        begin
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load)
        begin
            row_sum_reg <= row_sum_next;
            r_meta_reg  <= p_meta_reg;
        end
    end

    assign t_load = r_valid_reg && en_t;

    // ------------------------------------------------------------------
    // Stage T: total, drop the 14 fraction bits (floor), wrap to 22 bits.
    // This is the output register.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]    total_sum;
    logic signed [SUM_W-1:0]    total_shift;
    logic signed [RESULT_W-1:0] t_value_reg;
    meta_t                      t_meta_reg;

    always_comb
    begin
        total_sum = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            total_sum = total_sum + SUM_W'(row_sum_reg[r]);
        end
        total_shift = total_sum >>> FRAC_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else if (en_t)
        begin
            t_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_load)
        begin
            t_value_reg <= total_shift[RESULT_W-1:0];
            t_meta_reg  <= r_meta_reg;
        end
    end

    assign result.valid          = t_valid_reg;
    assign result.filtered_value = t_value_reg;
    assign result.out_row        = t_meta_reg.out_row;
    assign result.out_col        = t_meta_reg.out_col;
    assign result.frame_last     = t_meta_reg.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted pixel lands in S1 as a pixel request
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> (s1_valid_reg && !s1_load_reg))
        else $error("accepted pixel did not reach stage S1");

    // The last pixel of a frame returns the position to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && frame_end) |=> (col_reg == '0 && row_reg == '0 && slot_reg == '0))
        else $error("position counters did not wrap at frame end");

    // A window whose products are not yet taken must not shift
    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid_reg && !en_p) |=> $stable(pix[0][0]))
        else $error("window moved while its products were pending");

    // A coefficient load never turns into a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_load_reg) |=> !w_valid_reg)
        else $error("coefficient load produced a window result");

endmodule
